// File: sv/sbcp_pkg.sv
// Shared types, constants and helpers for the segment box clip parameters block.
package sbcp_pkg;

	// Fixed-point fraction bits of the clip parameters.
	localparam int FRAC_BITS = 16;
	// Four box edges, visited left, right, top, bottom.
	localparam int LANES = 4;
	localparam int QBITS = 32;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES = QBITS / STEPS_PER_STAGE;
	localparam int PQ_W = 34;
	localparam int DEN_W = 33;
	localparam int NUM_W = PQ_W + FRAC_BITS;
	localparam int HIGH_W = NUM_W - QBITS;

	// Edge normal codes.
	typedef enum logic [2:0] {
		NORM_NONE   = 3'd0,
		NORM_MINUSX = 3'd1,
		NORM_PLUSX  = 3'd2,
		NORM_MINUSY = 3'd3,
		NORM_PLUSY  = 3'd4
	} normal_t;

	localparam normal_t LANE_NORMAL [LANES] = '{NORM_MINUSX, NORM_PLUSX, NORM_MINUSY, NORM_PLUSY};

	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] T_ONE = 32'sd1 <<< FRAC_BITS;

	// One edge's divider state as it moves down the pipeline.
	typedef struct packed {
		logic                 pzero;
		logic                 pneg;
		logic                 qnonpos;
		logic                 neg;
		logic                 ovf;
		logic [DEN_W-1:0]     den;
		logic [DEN_W:0]       rem;
		logic [QBITS-1:0]     num;
		logic [QBITS-1:0]     quo;
	} lane_t;

	// Running clip state carried through the edge stages.
	typedef struct packed {
		logic               hit;
		logic signed [31:0] t1;
		logic signed [31:0] t2;
		normal_t            n1;
		normal_t            n2;
	} clip_t;

	// One restoring division step: brings in the next numerator bit.
	function automatic lane_t div_step(lane_t l);
		lane_t          o;
		logic [DEN_W:0] t;
		o = l;
		t = {l.rem[DEN_W-1:0], l.num[QBITS-1]};
		o.num = {l.num[QBITS-2:0], 1'b0};
		if (t >= {1'b0, l.den}) begin
			o.rem = t - {1'b0, l.den};
			o.quo = {l.quo[QBITS-2:0], 1'b1};
		end else begin
			o.rem = t;
			o.quo = {l.quo[QBITS-2:0], 1'b0};
		end
		return o;
	endfunction

	// Signed and saturated ratio from a finished division.
	function automatic logic signed [31:0] sat_ratio(lane_t l);
		logic signed [31:0] r;
		if (l.neg) begin
			if (l.ovf || (l.quo[QBITS-1] && (|l.quo[QBITS-2:0]))) r = T_MIN;
			else r = $signed(32'd0 - l.quo);
		end else begin
			if (l.ovf || l.quo[QBITS-1]) r = T_MAX;
			else r = $signed(l.quo);
		end
		return r;
	endfunction

endpackage

// File: sv/segment_box_clip_parameters_unit.sv
// Top level of the pipelined Liang-Barsky segment against box clipper.
//
// Usage: drive the box, the segment end points and the two open flags and
// raise start for one cycle per request. busy is always low, so a request
// may be issued in every clock cycle; the unit takes one request per cycle.
// Each request yields exactly one result, shown for one cycle with done
// high on hit, t_enter, t_exit, enter_normal and exit_normal. Results
// leave in request order.
// Four parallel restoring dividers, one per edge, form the edge ratios
// to 32 quotient bits in eight stages of four bits each. The pipeline
// also holds one stage forming p and q, one setting up the division, one
// saturating the ratios and four applying the edges in order left,
// right, top, bottom.
// Reset empties the pipeline: no result is shown for any request in
// flight. The receiver cannot stall, so results are never held back.
module segment_box_clip_parameters_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   box_left,
	input  logic signed [31:0]   box_top,
	input  logic [30:0]          box_width,
	input  logic [30:0]          box_height,
	input  logic signed [31:0]   start_x,
	input  logic signed [31:0]   start_y,
	input  logic signed [31:0]   end_x,
	input  logic signed [31:0]   end_y,
	input  logic                 open_before,
	input  logic                 open_after,
	output logic                 done,
	output logic                 hit,
	output logic signed [31:0]   t_enter,
	output logic signed [31:0]   t_exit,
	output sbcp_pkg::normal_t    enter_normal,
	output sbcp_pkg::normal_t    exit_normal
);
	import sbcp_pkg::*;

	logic                     accept;
	logic signed [PQ_W-1:0]   dx, dy;
	logic signed [PQ_W-1:0]   p_c [LANES];
	logic signed [PQ_W-1:0]   q_c [LANES];

	logic                     vld_s1;
	logic                     ob_s1, oa_s1;
	logic signed [PQ_W-1:0]   p_s1 [LANES];
	logic signed [PQ_W-1:0]   q_s1 [LANES];

	lane_t                    setup_c [LANES];
	lane_t                    div_s [DIV_STAGES+1][LANES];
	lane_t                    div_nxt [DIV_STAGES][LANES];
	logic                     vld_div_s [DIV_STAGES+1];
	logic                     ob_div_s [DIV_STAGES+1];
	logic                     oa_div_s [DIV_STAGES+1];

	logic signed [31:0]       r_s [LANES][LANES];
	lane_t                    fl_s [LANES][LANES];
	clip_t                    clip_s [LANES+1];
	clip_t                    clip_nxt [LANES];
	logic                     vld_clip_s [LANES+1];

	assign busy   = 1'b0;
	assign accept = start;

	// Edge terms p and q, exact in 34 bits.
	always_comb begin
		dx = PQ_W'(end_x) - PQ_W'(start_x);
		dy = PQ_W'(end_y) - PQ_W'(start_y);
		p_c[0] = -dx;
		q_c[0] = PQ_W'(start_x) - PQ_W'(box_left);
		p_c[1] = dx;
		q_c[1] = PQ_W'(box_left) + $signed({3'b000, box_width}) - PQ_W'(start_x);
		p_c[2] = -dy;
		q_c[2] = PQ_W'(start_y) - PQ_W'(box_top);
		p_c[3] = dy;
		q_c[3] = PQ_W'(box_top) + $signed({3'b000, box_height}) - PQ_W'(start_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ob_s1 <= open_before;
		oa_s1 <= open_after;
		for (int i = 0; i < LANES; i++) begin
			p_s1[i] <= p_c[i];
			q_s1[i] <= q_c[i];
		end
	end

	// Division set-up: magnitudes, result sign and early overflow check.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [PQ_W-1:0]  pa, qa;
			logic [NUM_W-1:0] nfull;
			logic [HIGH_W-1:0] nhigh;
			pa = p_s1[i][PQ_W-1] ? PQ_W'(-p_s1[i]) : PQ_W'(p_s1[i]);
			qa = q_s1[i][PQ_W-1] ? PQ_W'(-q_s1[i]) : PQ_W'(q_s1[i]);
			nfull = {qa, {FRAC_BITS{1'b0}}};
			nhigh = nfull[NUM_W-1:QBITS];
			setup_c[i].pzero   = (p_s1[i] == '0);
			setup_c[i].pneg    = p_s1[i][PQ_W-1];
			setup_c[i].qnonpos = q_s1[i][PQ_W-1] || (q_s1[i] == '0);
			setup_c[i].neg     = p_s1[i][PQ_W-1] ^ q_s1[i][PQ_W-1];
			setup_c[i].den     = pa[DEN_W-1:0];
			setup_c[i].ovf     = (DEN_W'(nhigh) >= pa[DEN_W-1:0]);
			setup_c[i].rem     = (DEN_W+1)'(nhigh);
			setup_c[i].num     = nfull[QBITS-1:0];
			setup_c[i].quo     = '0;
		end
	end

	// Divider stages, four quotient bits each.
	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int i = 0; i < LANES; i++) begin
				lane_t t;
				t = div_s[k][i];
				for (int j = 0; j < STEPS_PER_STAGE; j++) begin
					t = div_step(t);
				end
				div_nxt[k][i] = t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) vld_div_s[k] <= 1'b0;
		end else begin
			vld_div_s[0] <= vld_s1;
			for (int k = 0; k < DIV_STAGES; k++) vld_div_s[k+1] <= vld_div_s[k];
		end
	end

	always_ff @(posedge clk) begin
		ob_div_s[0] <= ob_s1;
		oa_div_s[0] <= oa_s1;
		for (int i = 0; i < LANES; i++) div_s[0][i] <= setup_c[i];
		for (int k = 0; k < DIV_STAGES; k++) begin
			ob_div_s[k+1] <= ob_div_s[k];
			oa_div_s[k+1] <= oa_div_s[k];
			for (int i = 0; i < LANES; i++) div_s[k+1][i] <= div_nxt[k][i];
		end
	end

	// Saturate the ratios and seed the clip state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LANES; k++) vld_clip_s[k] <= 1'b0;
		end else begin
			vld_clip_s[0] <= vld_div_s[DIV_STAGES];
			for (int k = 0; k < LANES; k++) vld_clip_s[k+1] <= vld_clip_s[k];
		end
	end

	// The ratios travel alongside the clip state so that each edge stage
	// sees the ratios of its own request.
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			r_s[0][i]  <= sat_ratio(div_s[DIV_STAGES][i]);
			fl_s[0][i] <= div_s[DIV_STAGES][i];
		end
		for (int k = 0; k < LANES - 1; k++) begin
			for (int i = 0; i < LANES; i++) begin
				r_s[k+1][i]  <= r_s[k][i];
				fl_s[k+1][i] <= fl_s[k][i];
			end
		end
		clip_s[0].hit <= 1'b1;
		clip_s[0].t1  <= ob_div_s[DIV_STAGES] ? T_MIN : 32'sd0;
		clip_s[0].t2  <= oa_div_s[DIV_STAGES] ? T_MAX : T_ONE;
		clip_s[0].n1  <= NORM_NONE;
		clip_s[0].n2  <= NORM_NONE;
		for (int k = 0; k < LANES; k++) clip_s[k+1] <= clip_nxt[k];
	end

	// Edge stages: each applies one edge to the running interval.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			clip_t c;
			c = clip_s[k];
			if (c.hit) begin
				if (fl_s[k][k].pzero) begin
					if (fl_s[k][k].qnonpos) c.hit = 1'b0;
				end else if (fl_s[k][k].pneg) begin
					if (r_s[k][k] > c.t2) c.hit = 1'b0;
					else if (r_s[k][k] > c.t1) begin
						c.t1 = r_s[k][k];
						c.n1 = LANE_NORMAL[k];
					end
				end else begin
					if (r_s[k][k] < c.t1) c.hit = 1'b0;
					else if (r_s[k][k] < c.t2) begin
						c.t2 = r_s[k][k];
						c.n2 = LANE_NORMAL[k];
					end
				end
			end
			clip_nxt[k] = c;
		end
	end

	// Result ports; a miss reports all zeros.
	assign done         = vld_clip_s[LANES];
	assign hit          = clip_s[LANES].hit;
	assign t_enter      = clip_s[LANES].hit ? clip_s[LANES].t1 : 32'sd0;
	assign t_exit       = clip_s[LANES].hit ? clip_s[LANES].t2 : 32'sd0;
	assign enter_normal = clip_s[LANES].hit ? clip_s[LANES].n1 : NORM_NONE;
	assign exit_normal  = clip_s[LANES].hit ? clip_s[LANES].n2 : NORM_NONE;

endmodule
